// ===== rtl/r2fft_pkg.sv =====
package r2fft_pkg;

  localparam int DATA_W      = 26;
  localparam int TW_W        = 16;
  localparam int PROD_W      = DATA_W + TW_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int ROUND_SHIFT = 15;
  localparam int T_W         = SUM_W - ROUND_SHIFT;
  localparam int ADD_W       = T_W + 1;
  localparam int MODE_W      = 2;
  localparam int OUT_TDATA_W = ((2 * DATA_W + 7) / 8) * 8;

  localparam int DEF_POINTS      = 512;
  localparam int DEF_LOG2_POINTS = 9;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] im;
    logic signed [DATA_W-1:0] re;
  } cplx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_BR_RA,
    S_BR_RB,
    S_BR_WA,
    S_BR_WB,
    S_BF_RA,
    S_BF_RB,
    S_BF_LD,
    S_BF_WAIT,
    S_BF_WA,
    S_BF_WB
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ADD_W-1:0] v);
    logic signed [ADD_W-1:0] hi;
    logic signed [ADD_W-1:0] lo;
    hi = ADD_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - ADD_W'(1);
    if (v > hi) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/r2fft_ram.sv =====
module r2fft_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/r2fft_bfly.sv =====
module r2fft_bfly
  import r2fft_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  cplx_t                  a,
  input  cplx_t                  b,
  input  logic signed [TW_W-1:0] c,
  input  logic signed [TW_W-1:0] s,
  output logic                   done,
  output cplx_t                  a_out,
  output cplx_t                  b_out
);

  localparam logic [2:0] PH_LAST = 3'd6;

  logic [2:0]                ph_r;
  cplx_t                     a_r, b_r, a_out_r, b_out_r;
  logic signed [TW_W-1:0]    c_r, s_r;
  logic signed [PROD_W-1:0]  prod_r, acc_r;
  logic signed [T_W-1:0]     tr_r, ti_r;
  logic                      done_r;
  logic signed [TW_W-1:0]    mul_a;
  logic signed [DATA_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [SUM_W-1:0]   sum_add, sum_sub;
  logic signed [SUM_W-1:0]   rnd_add, rnd_sub;

  // One multiplier serves all four partial products: c*br, s*bi, c*bi, s*br.
  assign mul_a    = (ph_r == 3'd1 || ph_r == 3'd3) ? c_r : s_r;
  assign mul_b    = (ph_r == 3'd1 || ph_r == 3'd4) ? b_r.re : b_r.im;
  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign sum_add = SUM_W'(acc_r) + SUM_W'(prod_r);
  assign sum_sub = SUM_W'(acc_r) - SUM_W'(prod_r);
  assign rnd_add = sum_add + SUM_W'(1 << (ROUND_SHIFT - 1));
  assign rnd_sub = sum_sub + SUM_W'(1 << (ROUND_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ph_r <= 3'd1;
      end else if (ph_r == PH_LAST) begin
        ph_r   <= '0;
        done_r <= 1'b1;
      end else if (ph_r != 3'd0) begin
        ph_r <= ph_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      c_r <= c;
      s_r <= s;
    end
    if (ph_r != 3'd0) begin
      prod_r <= prod_nxt;
    end
    if (ph_r == 3'd2 || ph_r == 3'd4) begin
      acc_r <= prod_r;
    end
    if (ph_r == 3'd3) begin
      tr_r <= rnd_add[SUM_W-1:ROUND_SHIFT];
    end
    if (ph_r == 3'd5) begin
      ti_r <= rnd_sub[SUM_W-1:ROUND_SHIFT];
    end
    if (ph_r == PH_LAST) begin
      a_out_r.re <= sat_data(ADD_W'(a_r.re) + ADD_W'(tr_r));
      a_out_r.im <= sat_data(ADD_W'(a_r.im) + ADD_W'(ti_r));
      b_out_r.re <= sat_data(ADD_W'(a_r.re) - ADD_W'(tr_r));
      b_out_r.im <= sat_data(ADD_W'(a_r.im) - ADD_W'(ti_r));
    end
  end

  assign done  = done_r;
  assign a_out = a_out_r;
  assign b_out = b_out_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ph_r == 3'd0)
    else $error("butterfly started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(ph_r == PH_LAST))
    else $error("butterfly done without finishing its phases");

  a_phase_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != 3'd0 && ph_r != PH_LAST && !start) |=> ph_r == $past(ph_r) + 3'd1)
    else $error("butterfly phase skipped");

endmodule

// ===== rtl/radix2_fft_engine.sv =====
// In-place forward radix-2 decimation-in-time FFT over POINTS complex samples,
// twiddles exp(-j2*pi*P/POINTS) in Q1.15, products rounded, no stage scaling and
// every stored value saturated to 26 bits signed. Items carry a mode in in_tuser:
// load writes one sample, read returns one bin through the memory's registered
// read port and the output register, and run performs the bit-reversal reorder
// and all LOG2_POINTS stages. The sample store is one memory with one write and
// one registered read port, and all butterflies share one multiplier: the reorder
// checks each index once and reads and writes back each swapped pair, and each
// butterfly goes through two reads, a start, six multiplier and add phases, a
// done strobe and two writes. The block is not ready during run, nor while a
// read is in flight or its result waits on the output. Bins never loaded read
// as garbage.
module radix2_fft_engine
  import r2fft_pkg::*;
#(
  parameter int POINTS      = DEF_POINTS,
  parameter int LOG2_POINTS = DEF_LOG2_POINTS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int IN_TDATA_W = ((LOG2_POINTS + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: index, sample_real, sample_imag, zero fill.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: mode.
  input  logic [MODE_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: bin_real, bin_imag, zero fill.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW   = LOG2_POINTS;
  localparam int NB   = LOG2_POINTS - 1;
  localparam int SCW  = $clog2(LOG2_POINTS);
  localparam int HALF = POINTS / 2;

  typedef logic [2*TW_W-1:0] tw_rom_t [HALF];

  function automatic tw_rom_t build_tw();
    tw_rom_t rom;
    real     ang;
    real     cv;
    real     sv;
    int      ci;
    int      si;
    for (int p = 0; p < HALF; p++) begin
      ang = 2.0 * 3.14159265358979324 * p / POINTS;
      cv  = $floor($cos(ang) * 32768.0 + 0.5);
      sv  = $floor($sin(ang) * 32768.0 + 0.5);
      ci  = (cv > 32767.0) ? 32767 : $rtoi(cv);
      si  = (sv > 32767.0) ? 32767 : $rtoi(sv);
      rom[p] = {TW_W'(si), TW_W'(ci)};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw();

  state_t st_r, st_nxt;

  logic [AW-1:0]            i_r, i_nxt;
  logic [NB-1:0]            n_r, n_nxt;
  logic [SCW-1:0]           sc_r, sc_nxt;
  cplx_t                    a_r, a_nxt;
  cplx_t                    out_data_r, out_data_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [2*TW_W-1:0]        tw_r;

  logic                     in_fire;
  logic [MODE_W-1:0]        in_mode;
  logic [AW-1:0]            in_index;
  logic signed [SAMPLE_BITS-1:0] in_real, in_imag;

  logic [AW-1:0]            rev_i;
  logic [NB-1:0]            low_mask;
  logic [AW-1:0]            k_lo, k_hi;
  logic [NB-1:0]            tw_idx;
  logic [SCW-1:0]           tw_shift;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  cplx_t                    ram_wdata, ram_rdata;

  logic                     bf_start, bf_done;
  cplx_t                    bf_a_out, bf_b_out;

  assign in_mode  = in_tuser;
  assign in_index = in_tdata[AW-1:0];
  assign in_real  = in_tdata[AW +: SAMPLE_BITS];
  assign in_imag  = in_tdata[AW + SAMPLE_BITS +: SAMPLE_BITS];
  assign in_tready = (st_r == S_IDLE) && !out_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_i[AW-1-b] = i_r[b];
    end
  end

  // Butterfly n of a stage pairs k_lo and k_lo + half, half = 2^sc.
  assign low_mask = (NB'(1) << sc_r) - NB'(1);
  assign k_lo     = {n_r & ~low_mask, 1'b0} | {1'b0, n_r & low_mask};
  assign k_hi     = k_lo | (AW'(1) << sc_r);
  assign tw_shift = SCW'(LOG2_POINTS - 1) - sc_r;
  assign tw_idx   = (n_r & low_mask) << tw_shift;

  r2fft_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  r2fft_bfly u_bfly (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bf_start),
    .a     (a_r),
    .b     (ram_rdata),
    .c     (tw_r[TW_W-1:0]),
    .s     (tw_r[2*TW_W-1:TW_W]),
    .done  (bf_done),
    .a_out (bf_a_out),
    .b_out (bf_b_out)
  );

  always_ff @(posedge clk) begin
    tw_r <= TW_ROM[tw_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    n_r        <= n_nxt;
    sc_r       <= sc_nxt;
    a_r        <= a_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    sc_nxt        = sc_r;
    a_nxt         = a_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = i_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = i_r;
    bf_start      = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        ram_raddr = in_index;
        ram_waddr = in_index;
        ram_wdata.re = DATA_W'(in_real);
        ram_wdata.im = DATA_W'(in_imag);
        if (in_fire) begin
          unique case (in_mode)
            MODE_LOAD: ram_we = 1'b1;
            MODE_RUN: begin
              i_nxt  = '0;
              st_nxt = S_BR_RA;
            end
            MODE_READ: st_nxt = S_RD;
            default: ;
          endcase
        end
      end
      S_RD: begin
        out_data_nxt  = ram_rdata;
        out_valid_nxt = 1'b1;
        st_nxt        = S_IDLE;
      end
      S_BR_RA: begin
        if (rev_i > i_r) begin
          st_nxt = S_BR_RB;
        end else if (i_r == {AW{1'b1}}) begin
          n_nxt  = '0;
          sc_nxt = '0;
          st_nxt = S_BF_RA;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      S_BR_RB: begin
        ram_raddr = rev_i;
        a_nxt     = ram_rdata;
        st_nxt    = S_BR_WA;
      end
      S_BR_WA: begin
        ram_we = 1'b1;
        st_nxt = S_BR_WB;
      end
      S_BR_WB: begin
        ram_we    = 1'b1;
        ram_waddr = rev_i;
        ram_wdata = a_r;
        if (i_r == {AW{1'b1}}) begin
          n_nxt  = '0;
          sc_nxt = '0;
          st_nxt = S_BF_RA;
        end else begin
          i_nxt  = i_r + AW'(1);
          st_nxt = S_BR_RA;
        end
      end
      S_BF_RA: begin
        ram_raddr = k_lo;
        st_nxt    = S_BF_RB;
      end
      S_BF_RB: begin
        ram_raddr = k_hi;
        a_nxt     = ram_rdata;
        st_nxt    = S_BF_LD;
      end
      S_BF_LD: begin
        bf_start = 1'b1;
        st_nxt   = S_BF_WAIT;
      end
      S_BF_WAIT: begin
        if (bf_done) begin
          st_nxt = S_BF_WA;
        end
      end
      S_BF_WA: begin
        ram_we    = 1'b1;
        ram_waddr = k_lo;
        ram_wdata = bf_a_out;
        st_nxt    = S_BF_WB;
      end
      S_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = k_hi;
        ram_wdata = bf_b_out;
        n_nxt     = n_r + NB'(1);
        st_nxt    = S_BF_RA;
        if (n_r == {NB{1'b1}}) begin
          sc_nxt = sc_r + SCW'(1);
          if (sc_r == SCW'(LOG2_POINTS - 1)) begin
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  a_bf_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    bf_done |-> st_r == S_BF_WAIT)
    else $error("butterfly result arrived outside its wait state");

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_RD))
    else $error("result item without a read");

  a_swap_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_BR_WB |-> rev_i > i_r)
    else $error("reorder swap of an index with itself or a lower one");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == MODE_RUN) |=> !in_tready)
    else $error("input taken while transform runs");

endmodule
